FILE: sv/rba_pkg.sv
package rba_pkg;

  localparam int unsigned CACHE_RESET = 8388608;
  localparam int unsigned CACHE_CAP   = 16777216;
  localparam int unsigned SPLIT_MIN   = 256;

  localparam logic [1:0] KIND_EVICT = 2'd0;
  localparam logic [1:0] KIND_GRANT = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SIZE  = 2'd1;
  localparam logic [1:0] ERR_LARGE = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_PREV,
    CELL_LOAD,
    CELL_DROP
  } cell_op_t;

  typedef struct packed {
    logic [23:0] offset;
    logic [24:0] size;
    logic [15:0] owner;
    logic        owned;
  } entry_t;

  typedef struct packed {
    logic        mode;
    logic [22:0] request_bytes;
    logic [15:0] owner_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag;
    logic [23:0] offset;
    logic [24:0] granted_bytes;
    logic [1:0]  error_code;
    logic        thrash;
    logic        last;
  } out_t;

endpackage

FILE: sv/rba_cell.sv
module rba_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rba_pkg::cell_op_t op,
  input  rba_pkg::entry_t   prev_entry,
  input  rba_pkg::entry_t   next_entry,
  input  rba_pkg::entry_t   load_entry,
  output rba_pkg::entry_t   entry
);
  import rba_pkg::*;

  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (op)
      CELL_HOLD: ent_nxt = ent_r;
      CELL_NEXT: ent_nxt = next_entry;
      CELL_PREV: ent_nxt = prev_entry;
      CELL_LOAD: ent_nxt = load_entry;
      CELL_DROP: ent_nxt.owned = 1'b0;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.offset <= '0;
      ent_r.size   <= 25'(CACHE_RESET);
      ent_r.owner  <= '0;
      ent_r.owned  <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign entry = ent_r;

endmodule

FILE: sv/rover_block_allocator.sv
// Rover block allocator. Pulse start with busy low to issue a request: an
// allocate (mode 0) or a flush (mode 1). Results come back one per cycle on
// out_res, each marked by a one-cycle out_strobe and taken as it appears;
// the final result of a request has last set and shows in the same cycle
// that busy drops. Size errors answer in the cycle after the request and
// leave busy low. An allocate walks blocks from the rover to the end of the
// merge, absorbing all but the first of them, and may split off a leftover;
// a flush walks every block, evicting the owned ones, then reports. The
// table lives in a row of MAX_BLOCKS cells that shift toward or away from
// the rover one step a cycle, and a read mux over the row at the walk index
// paces the walk.
module rover_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = 32,
  parameter int unsigned MAX_REQUEST = 4194304
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rba_pkg::in_t  in_req,
  input  logic          cfg_we,
  input  logic [24:0]   cfg_wdata,
  output logic          out_strobe,
  output rba_pkg::out_t out_res
);
  import rba_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ROVER = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_MERGE = 4'd3;
  localparam logic [3:0] ST_SHL   = 4'd4;
  localparam logic [3:0] ST_SPLIT = 4'd5;
  localparam logic [3:0] ST_GRANT = 4'd6;
  localparam logic [3:0] ST_FLUSH = 4'd7;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rover_r, rover_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          wrap_r, wrap_nxt;
  logic [24:0]   cache_r;
  logic [15:0]   tag_r, tag_nxt;
  logic [22:0]   sz_r, sz_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [25:0]   acc_r, acc_nxt;
  logic          ostb_r, ostb_nxt;
  out_t          ores_r, ores_nxt;

  entry_t   ent [MAX_BLOCKS];
  cell_op_t ops [MAX_BLOCKS];
  entry_t   load_ent;
  entry_t   rd_j, rd_r, rd_rov;

  logic [24:0] eff;
  logic [23:0] req_sz;
  logic        req_bad;
  logic        step;
  logic [25:0] spare;

  // cell row: neighbors hand entries left or right
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    rba_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (ops[i]),
      .prev_entry ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == MAX_BLOCKS - 1) ? ent[i] : ent[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .load_entry (load_ent),
      .entry      (ent[i])
    );
  end

  assign rd_j   = ent[j_r[AW-1:0]];
  assign rd_r   = ent[r_r[AW-1:0]];
  assign rd_rov = ent[rover_r[AW-1:0]];

  always_comb begin
    eff = (cache_r > 25'(CACHE_CAP)) ? 25'(CACHE_CAP) : cache_r;
    eff[1:0] = 2'b00;
  end

  assign req_sz  = (24'(in_req.request_bytes) + 24'd3) & ~24'd3;
  assign req_bad = (in_req.request_bytes == '0) ||
                   (32'(in_req.request_bytes) > 32'(MAX_REQUEST));
  assign step    = (j_r == r_r) || ((acc_r < 26'(sz_r)) && (j_r < count_r));
  assign spare   = acc_r - 26'(sz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) cache_r <= 25'(CACHE_RESET);
    else if (cfg_we) cache_r <= cfg_wdata;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rover_nxt   = rover_r;
    wrapped_nxt = wrapped_r;
    wrap_nxt    = wrap_r;
    tag_nxt     = tag_r;
    sz_nxt      = sz_r;
    r_nxt       = r_r;
    j_nxt       = j_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    ostb_nxt    = 1'b0;
    ores_nxt    = '0;
    load_ent    = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) ops[i] = CELL_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tag_nxt = in_req.owner_tag;
          sz_nxt  = req_sz[22:0];
          j_nxt   = '0;
          if (in_req.mode == MODE_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else if (req_bad) begin
            ostb_nxt = 1'b1;
            ores_nxt.kind = KIND_ERROR;
            ores_nxt.tag = in_req.owner_tag;
            ores_nxt.error_code = ERR_SIZE;
            ores_nxt.last = 1'b1;
          end else if (25'(req_sz) > eff) begin
            ostb_nxt = 1'b1;
            ores_nxt.kind = KIND_ERROR;
            ores_nxt.tag = in_req.owner_tag;
            ores_nxt.error_code = ERR_LARGE;
            ores_nxt.last = 1'b1;
          end else begin
            state_nxt = ST_ROVER;
          end
        end
      end
      ST_ROVER: begin
        wrap_nxt = 1'b0;
        if (rover_r >= count_r) begin
          r_nxt = '0;
        end else if (25'(rd_rov.offset) > eff - 25'(sz_r)) begin
          wrap_nxt = 1'b1;
          r_nxt = '0;
        end else begin
          r_nxt = rover_r;
        end
        j_nxt     = r_nxt;
        acc_nxt   = '0;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if ((j_r < count_r) && (acc_r < 26'(sz_r))) begin
          acc_nxt = acc_r + 26'(rd_j.size);
          j_nxt   = j_r + 1'b1;
        end else if (acc_r < 26'(sz_r)) begin
          ostb_nxt = 1'b1;
          ores_nxt.kind = KIND_ERROR;
          ores_nxt.tag = tag_r;
          ores_nxt.error_code = ERR_LARGE;
          ores_nxt.last = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          j_nxt     = r_r;
          acc_nxt   = '0;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (step) begin
          if (rd_j.owned) begin
            ops[j_r[AW-1:0]] = CELL_DROP;
            ostb_nxt = 1'b1;
            ores_nxt.kind = KIND_EVICT;
            ores_nxt.tag = rd_j.owner;
            ores_nxt.offset = rd_j.offset;
          end
          acc_nxt = acc_r + 26'(rd_j.size);
          j_nxt   = j_r + 1'b1;
        end else begin
          rem_nxt   = j_r - r_r - 1'b1;
          state_nxt = ST_SHL;
        end
      end
      ST_SHL: begin
        if (rem_r != '0) begin
          // close the gap left by absorbed blocks
          for (int i = 0; i < MAX_BLOCKS; i++)
            if (CW'(i) > r_r) ops[i] = CELL_NEXT;
          count_nxt = count_r - 1'b1;
          rem_nxt   = rem_r - 1'b1;
        end else if ((spare > 26'(SPLIT_MIN)) && (32'(count_r) < 32'(MAX_BLOCKS))) begin
          state_nxt = ST_SPLIT;
        end else begin
          state_nxt = ST_GRANT;
        end
      end
      ST_SPLIT: begin
        for (int i = 0; i < MAX_BLOCKS; i++)
          if (CW'(i) > r_r + 1'b1) ops[i] = CELL_PREV;
        ops[AW'(r_r + 1'b1)] = CELL_LOAD;
        load_ent.offset = rd_r.offset + 24'(sz_r);
        load_ent.size   = spare[24:0];
        count_nxt = count_r + 1'b1;
        acc_nxt   = 26'(sz_r);
        state_nxt = ST_GRANT;
      end
      ST_GRANT: begin
        ops[r_r[AW-1:0]] = CELL_LOAD;
        load_ent.offset = rd_r.offset;
        load_ent.size   = acc_r[24:0];
        load_ent.owner  = tag_r;
        load_ent.owned  = 1'b1;
        rover_nxt = r_r + 1'b1;
        ostb_nxt = 1'b1;
        ores_nxt.kind = KIND_GRANT;
        ores_nxt.tag = tag_r;
        ores_nxt.offset = rd_r.offset;
        ores_nxt.granted_bytes = acc_r[24:0];
        ores_nxt.last = 1'b1;
        if (wrapped_r) ores_nxt.thrash = wrap_r || (rover_nxt < count_r);
        else if (wrap_r) wrapped_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (j_r < count_r) begin
          if (rd_j.owned) begin
            ops[j_r[AW-1:0]] = CELL_DROP;
            ostb_nxt = 1'b1;
            ores_nxt.kind = KIND_EVICT;
            ores_nxt.tag = rd_j.owner;
            ores_nxt.offset = rd_j.offset;
          end
          j_nxt = j_r + 1'b1;
        end else begin
          ops[0] = CELL_LOAD;
          load_ent.size = eff;
          count_nxt = CW'(1);
          rover_nxt = '0;
          ostb_nxt = 1'b1;
          ores_nxt.kind = KIND_FLUSH;
          ores_nxt.last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= CW'(1);
      rover_r   <= '0;
      wrapped_r <= 1'b0;
      ostb_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rover_r   <= rover_nxt;
      wrapped_r <= wrapped_nxt;
      ostb_r    <= ostb_nxt;
    end
    wrap_r <= wrap_nxt;
    tag_r  <= tag_nxt;
    sz_r   <= sz_nxt;
    r_r    <= r_nxt;
    j_r    <= j_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    ores_r <= ores_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = ostb_r;
  assign out_res    = ores_r;

endmodule

FILE: sv/rba_checker.sv
module rba_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input rba_pkg::in_t  in_req,
  input logic          out_strobe,
  input rba_pkg::out_t out_res
);
  import rba_pkg::*;

  // a flush always walks the table before it reports
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.mode == MODE_FLUSH |=> busy)
    else $error("flush did not go busy");

  a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.kind == KIND_GRANT |-> out_res.last)
    else $error("grant not last");

  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.kind == KIND_EVICT |-> !out_res.last)
    else $error("eviction marked last");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("reset did not clear control");

endmodule

bind rover_block_allocator rba_checker u_rba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

FILE: tb/tb_rover_block_allocator.sv
`timescale 1ns / 100ps

module tb_rover_block_allocator;
  import rba_pkg::*;

  localparam int NBLK = 32;
  localparam int MAXREQ = 4194304;
  localparam int LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_req;
  logic cfg_we;
  logic [24:0] cfg_wdata;
  logic out_strobe;
  out_t out_res;

  rover_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_strobe(out_strobe),
    .out_res(out_res)
  );

  // predictor copy of the block table
  logic [24:0] pr_cache;
  logic [23:0] pr_off [NBLK];
  logic [24:0] pr_size [NBLK];
  logic [15:0] pr_owner [NBLK];
  logic pr_owned [NBLK];
  int pr_count;
  int pr_rover;
  logic pr_wrapped;

  out_t pending_results[$];
  int fail_count;
  int cycle_count;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic out_t make_res(logic [1:0] k, logic [15:0] t, logic [23:0] o,
                                    logic [24:0] b, logic [1:0] e, logic th,
                                    logic l);
    out_t r;
    r.kind = k; r.tag = t; r.offset = o; r.granted_bytes = b;
    r.error_code = e; r.thrash = th; r.last = l;
    return r;
  endfunction

  function automatic int unsigned eff_cache();
    int unsigned c;
    c = 32'(pr_cache);
    if (c > CACHE_CAP) c = CACHE_CAP;
    return c & ~32'd3;
  endfunction

  task automatic evict_owned(int i);
    if (pr_owned[i]) begin
      pending_results.push_back(make_res(KIND_EVICT, pr_owner[i], pr_off[i], '0,
                                         ERR_NONE, 1'b0, 1'b0));
      pr_owned[i] = 1'b0;
    end
  endtask

  task automatic predict_request(in_t q);
    int unsigned sz, eff, total, merged, granted;
    int r, j, removed;
    logic wrap, thr;
    wrap = 1'b0; thr = 1'b0;
    if (q.mode == MODE_FLUSH) begin
      for (int i = 0; i < pr_count; i++) evict_owned(i);
      pr_count = 1; pr_off[0] = '0; pr_size[0] = 25'(eff_cache()); pr_owned[0] = 1'b0;
      pr_rover = 0;
      pending_results.push_back(make_res(KIND_FLUSH, '0, '0, '0, ERR_NONE, 1'b0, 1'b1));
      return;
    end
    if (q.request_bytes == 0 || q.request_bytes > MAXREQ) begin
      pending_results.push_back(make_res(KIND_ERROR, q.owner_tag, '0, '0, ERR_SIZE,
                                         1'b0, 1'b1));
      return;
    end
    sz = (q.request_bytes + 3) & ~32'd3;
    eff = eff_cache();
    if (sz > eff) begin
      pending_results.push_back(make_res(KIND_ERROR, q.owner_tag, '0, '0, ERR_LARGE,
                                         1'b0, 1'b1));
      return;
    end
    r = pr_rover;
    if (r >= pr_count) r = 0;
    else if (pr_off[r] > eff - sz) begin
      wrap = 1'b1; r = 0;
    end
    total = 0;
    for (j = r; j < pr_count && total < sz; j++) total += 32'(pr_size[j]);
    if (total < sz) begin
      pending_results.push_back(make_res(KIND_ERROR, q.owner_tag, '0, '0, ERR_LARGE,
                                         1'b0, 1'b1));
      return;
    end
    evict_owned(r);
    merged = 32'(pr_size[r]);
    j = r + 1;
    while (merged < sz && j < pr_count) begin
      evict_owned(j);
      merged += 32'(pr_size[j]);
      j++;
    end
    removed = j - r - 1;
    if (removed > 0) begin
      for (int i = j; i < pr_count; i++) begin
        pr_off[i-removed] = pr_off[i]; pr_size[i-removed] = pr_size[i];
        pr_owner[i-removed] = pr_owner[i]; pr_owned[i-removed] = pr_owned[i];
      end
      pr_count -= removed;
    end
    if (merged - sz > SPLIT_MIN && pr_count < NBLK) begin
      for (int i = pr_count; i > r + 1; i--) begin
        pr_off[i] = pr_off[i-1]; pr_size[i] = pr_size[i-1];
        pr_owner[i] = pr_owner[i-1]; pr_owned[i] = pr_owned[i-1];
      end
      pr_off[r+1] = pr_off[r] + sz[23:0];
      pr_size[r+1] = 25'(merged - sz);
      pr_owner[r+1] = '0; pr_owned[r+1] = 1'b0;
      pr_count++;
      granted = sz;
    end else granted = merged;
    pr_size[r] = 25'(granted); pr_owner[r] = q.owner_tag; pr_owned[r] = 1'b1;
    pr_rover = r + 1;
    if (pr_wrapped) thr = wrap || (pr_rover < pr_count);
    else if (wrap) pr_wrapped = 1'b1;
    pending_results.push_back(make_res(KIND_GRANT, q.owner_tag, pr_off[r], 25'(granted),
                                       ERR_NONE, thr, 1'b1));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %p", out_res);
      end else begin
        out_t e;
        e = pending_results.pop_front();
        if (e !== out_res) begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, out_res);
        end
      end
    end
  end

  bit quiet;

  // hold start until the request is taken; the next call or drain drops it
  task automatic send_request(in_t q);
    while (!quiet && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(q);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 && cycle_count < LIMIT) @(posedge clk);
    repeat (3 * NBLK + 20) @(posedge clk);
  endtask

  task automatic write_cache(logic [24:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    pr_cache = v;
  endtask

  function automatic in_t alloc_req(int unsigned b, logic [15:0] t);
    in_t q;
    q.mode = MODE_ALLOC; q.request_bytes = 23'(b); q.owner_tag = t;
    return q;
  endfunction

  function automatic in_t flush_req();
    in_t q;
    q.mode = MODE_FLUSH; q.request_bytes = 23'($urandom); q.owner_tag = 16'($urandom);
    return q;
  endfunction

  typedef struct {
    in_t q;
    bit typed;
    out_t res;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(in_t q, bit typed, out_t res);
    row_t rw;
    rw.q = q; rw.typed = typed; rw.res = res;
    dir_rows.push_back(rw);
  endtask

  task automatic random_alloc(int unsigned cap);
    int unsigned b;
    int p;
    p = $urandom_range(99);
    if (p < 3) b = 0;
    else if (p < 6) b = MAXREQ + $urandom_range(4194303 - MAXREQ + 4194303);
    else if (p < 12) b = $urandom_range(MAXREQ, 1);
    else b = $urandom_range((cap / 6 > 1) ? cap / 6 : 1, 1);
    if (b > 23'h7fffff) b = 23'h7fffff;
    send_request(alloc_req(b, 16'($urandom)));
  endtask

  initial begin
    logic [24:0] sizes[5];
    rst_n = 0; start = 0; in_req = '0; cfg_we = 0; cfg_wdata = '0;
    fail_count = 0; cycle_count = 0; quiet = 0;
    pr_cache = 25'(CACHE_RESET);
    for (int i = 0; i < NBLK; i++) begin
      pr_off[i] = '0; pr_size[i] = '0; pr_owner[i] = '0; pr_owned[i] = 1'b0;
    end
    pr_size[0] = 25'(CACHE_RESET); pr_count = 1; pr_rover = 0; pr_wrapped = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(alloc_req(0, 16'hffff), 1,
            make_res(KIND_ERROR, 16'hffff, '0, '0, ERR_SIZE, 1'b0, 1'b1));
    add_row(alloc_req(MAXREQ + 1, '0), 1,
            make_res(KIND_ERROR, '0, '0, '0, ERR_SIZE, 1'b0, 1'b1));
    add_row(alloc_req(23'h7fffff, 16'h1234), 1,
            make_res(KIND_ERROR, 16'h1234, '0, '0, ERR_SIZE, 1'b0, 1'b1));
    add_row(alloc_req(1, 16'haaaa), 1,
            make_res(KIND_GRANT, 16'haaaa, '0, 25'd4, ERR_NONE, 1'b0, 1'b1));
    add_row(alloc_req(MAXREQ, 16'h5555), 0, '0);
    add_row(alloc_req(MAXREQ, 16'h0001), 0, '0);
    add_row(alloc_req(MAXREQ, 16'h0002), 0, '0);
    add_row(alloc_req(258, 16'h0003), 0, '0);
    add_row(alloc_req(1000, 16'h0004), 0, '0);
    add_row(flush_req(), 0, '0);
    for (int k = 0; k < 34; k++) add_row(alloc_req(1 + 4 * k, 16'(k)), 0, '0);
    add_row(alloc_req(MAXREQ, 16'h0bad), 0, '0);
    add_row(flush_req(), 0, '0);

    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].q);
      if (dir_rows[k].typed && pending_results.size() != 0 &&
          pending_results[pending_results.size()-1] !== dir_rows[k].res) begin
        fail_count++;
        if (fail_count <= 10) $display("directed row %0d predicted wrongly", k);
      end
    end

    // cache larger than the table, then smallest cache: short table and too-large
    write_cache(25'd16777216);
    send_request(alloc_req(MAXREQ, 16'h0777));
    send_request(alloc_req(MAXREQ, 16'h0778));
    send_request(flush_req());
    write_cache(25'd256);
    send_request(alloc_req(257, 16'h0101));
    send_request(alloc_req(200, 16'h0102));
    send_request(alloc_req(100, 16'h0103));
    send_request(flush_req());

    sizes[0] = 25'd256; sizes[1] = 25'd4096; sizes[2] = 25'd65536;
    sizes[3] = 25'd16777216; sizes[4] = 25'h1ffffff;
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned cap;
      write_cache(ph == 5 ? 25'(CACHE_RESET) : sizes[$urandom_range(4)]);
      send_request(flush_req());
      cap = eff_cache();
      quiet = (ph == 2);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(99) < 4) send_request(flush_req());
        else random_alloc(cap);
      end
      quiet = 0;
    end

    drain();
    if (pending_results.size() == 0 && fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/rba_pkg.sv
sv/rba_cell.sv
sv/rover_block_allocator.sv
sv/rba_checker.sv
tb/tb_rover_block_allocator.sv
